// ===== hw/rtl/ucdw_pkg.sv =====
// ucdw_pkg: types, limits and codes for the usb configuration descriptor walker
// no dependencies; imported by ucdw_out_queue and usb_config_descriptor_walker
`default_nettype none

package ucdw_pkg;

  // limits
  localparam logic [3:0]  MAX_INTERFACES   = 4'd8;
  localparam logic [4:0]  MAX_ENDPOINTS    = 5'd16;
  localparam logic [15:0] CONFIG_MAX_BYTES = 16'd1024;

  // descriptor type codes
  localparam logic [7:0] TYPE_CONFIG    = 8'd2;
  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;

  // minimum descriptor lengths
  localparam logic [7:0] LEN_MIN       = 8'd2;
  localparam logic [7:0] LEN_CONFIG    = 8'd9;
  localparam logic [7:0] LEN_INTERFACE = 8'd9;
  localparam logic [7:0] LEN_ENDPOINT  = 8'd7;

  // record kinds
  localparam logic [1:0] KIND_CONFIG    = 2'd0;
  localparam logic [1:0] KIND_INTERFACE = 2'd1;
  localparam logic [1:0] KIND_ENDPOINT  = 2'd2;
  localparam logic [1:0] KIND_STATUS    = 2'd3;

  localparam logic STATUS_VALID   = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [2:0]  interface_slot;
    logic [3:0]  endpoint_slot;
    logic [63:0] bytes_low;
    logic [7:0]  byte_nine;
    logic        status;
    logic [15:0] drop_total;
    logic [3:0]  interfaces_kept;
    logic        end_of_run;
  } out_item_t;

  // records pushed into the queue for one input beat
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ucdw_out_queue.sv =====
// ucdw_out_queue: small result queue, up to two records written per cycle
// depends on ucdw_pkg
`default_nettype none

module ucdw_out_queue
  import ucdw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire push_t     push,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  out_item_t            entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 pop;
  logic [Q_PTR_W-1:0]   wr_ptr_second;

  assign out_valid = (count_r != '0);
  assign out_data  = entries_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for the worst case of two records from one beat
  assign room      = (count_r <= Q_CNT_W'(Q_DEPTH - 2));

  assign wr_ptr_second = wr_ptr_r + Q_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(push.count);
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries_r[wr_ptr_second] <= push.second;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/usb_config_descriptor_walker.sv =====
// usb_config_descriptor_walker: walks a configuration descriptor set byte by byte
// depends on ucdw_pkg and ucdw_out_queue
//
//  channel | ports                          | beat
//  --------+--------------------------------+-------------------------------------
//  input   | in_valid, in_ready, in_data    | one descriptor byte plus final flag
//  output  | out_valid, out_ready, out_data | one header, interface, endpoint or
//          |                                | status record
//
// one byte is taken per cycle while in_ready is high; its records are written
// into a four-entry result queue on the same edge and reach out_data in order
// a byte gives zero, one or two records; in_ready is low while fewer than
// two queue entries are free, so the output drain rate sets the pace
// synchronous active-low reset clears the walk state and empties the queue
// the final byte returns the walk state to its reset values
`default_nettype none

module usb_config_descriptor_walker
  import ucdw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [7:0]  desc_length_r, desc_length_nxt;
  logic [7:0]  desc_kind_r, desc_kind_nxt;
  logic [7:0]  desc_position_r, desc_position_nxt;
  logic [7:0]  desc_buffer_r [9];
  logic [7:0]  desc_buffer_nxt [9];
  logic [3:0]  interface_total_r, interface_total_nxt;
  logic [4:0]  endpoint_total_r, endpoint_total_nxt;
  logic        current_valid_r, current_valid_nxt;
  logic [15:0] drop_count_r, drop_count_nxt;
  logic        error_seen_r, error_seen_nxt;

  logic        accept;
  logic        room;
  logic [16:0] cnt;
  logic [7:0]  b;
  logic        emit_hdr, emit_fd, emit_st, bad, drop;
  out_item_t   rec_hdr, rec_fd, rec_st;
  push_t       push;
  logic [3:0]  slot_prev;

  assign accept    = in_valid && in_ready;
  assign in_ready  = room;
  assign b         = in_data.data_byte;
  assign cnt       = {1'b0, byte_count_r} + 17'd1;
  assign slot_prev = interface_total_r - 4'd1;

  always_comb begin
    byte_count_nxt      = byte_count_r;
    total_length_nxt    = total_length_r;
    desc_length_nxt     = desc_length_r;
    desc_kind_nxt       = desc_kind_r;
    desc_position_nxt   = desc_position_r;
    desc_buffer_nxt     = desc_buffer_r;
    interface_total_nxt = interface_total_r;
    endpoint_total_nxt  = endpoint_total_r;
    current_valid_nxt   = current_valid_r;
    drop_count_nxt      = drop_count_r;
    error_seen_nxt      = error_seen_r;
    emit_hdr            = 1'b0;
    emit_fd             = 1'b0;
    drop                = 1'b0;
    rec_hdr             = '0;
    rec_fd              = '0;
    rec_st              = '0;

    if (!error_seen_r) begin
      if (cnt > {1'b0, CONFIG_MAX_BYTES}) begin
        error_seen_nxt = 1'b1;
      end else begin
        byte_count_nxt = cnt[15:0];
        if (desc_position_r < 8'd9) begin
          desc_buffer_nxt[desc_position_r[3:0]] = b;
        end
        if (desc_position_r == 8'd0) begin
          desc_length_nxt = b;
          if (b < LEN_MIN || (cnt == 17'd1 && b < LEN_CONFIG)) begin
            error_seen_nxt = 1'b1;
          end
        end else if (desc_position_r == 8'd1) begin
          desc_kind_nxt = b;
        end

        // ninth byte closes the configuration header
        if (!error_seen_nxt && cnt == 17'd9) begin
          if (desc_buffer_nxt[1] != TYPE_CONFIG || desc_buffer_nxt[0] < LEN_CONFIG) begin
            error_seen_nxt = 1'b1;
          end else begin
            total_length_nxt    = {desc_buffer_nxt[3], desc_buffer_nxt[2]};
            emit_hdr            = 1'b1;
            rec_hdr.record_kind = KIND_CONFIG;
            rec_hdr.bytes_low   = {desc_buffer_nxt[7], desc_buffer_nxt[6],
                                   desc_buffer_nxt[5], desc_buffer_nxt[4],
                                   desc_buffer_nxt[3], desc_buffer_nxt[2],
                                   desc_buffer_nxt[1], desc_buffer_nxt[0]};
            rec_hdr.byte_nine   = desc_buffer_nxt[8];
          end
        end

        if (!error_seen_nxt) begin
          if ({1'b0, desc_position_r} + 9'd1 == {1'b0, desc_length_nxt}) begin
            desc_position_nxt = 8'd0;
            // last byte of a descriptor
            if (desc_kind_nxt == TYPE_INTERFACE && desc_length_nxt >= LEN_INTERFACE) begin
              if (desc_buffer_nxt[3] != 8'd0) begin
                current_valid_nxt = 1'b0;
              end else if (interface_total_r < MAX_INTERFACES) begin
                emit_fd                = 1'b1;
                rec_fd.record_kind     = KIND_INTERFACE;
                rec_fd.interface_slot  = interface_total_r[2:0];
                rec_fd.bytes_low       = {desc_buffer_nxt[7], desc_buffer_nxt[6],
                                          desc_buffer_nxt[5], desc_buffer_nxt[4],
                                          desc_buffer_nxt[3], desc_buffer_nxt[2],
                                          desc_buffer_nxt[1], desc_buffer_nxt[0]};
                rec_fd.byte_nine       = desc_buffer_nxt[8];
                interface_total_nxt    = interface_total_r + 4'd1;
                endpoint_total_nxt     = 5'd0;
                current_valid_nxt      = 1'b1;
              end else begin
                current_valid_nxt = 1'b0;
                drop              = 1'b1;
              end
            end else if (desc_kind_nxt == TYPE_ENDPOINT && desc_length_nxt >= LEN_ENDPOINT
                         && current_valid_r) begin
              if (endpoint_total_r < MAX_ENDPOINTS) begin
                emit_fd               = 1'b1;
                rec_fd.record_kind    = KIND_ENDPOINT;
                rec_fd.interface_slot = slot_prev[2:0];
                rec_fd.endpoint_slot  = endpoint_total_r[3:0];
                rec_fd.bytes_low      = {8'd0, desc_buffer_nxt[6],
                                         desc_buffer_nxt[5], desc_buffer_nxt[4],
                                         desc_buffer_nxt[3], desc_buffer_nxt[2],
                                         desc_buffer_nxt[1], desc_buffer_nxt[0]};
                endpoint_total_nxt    = endpoint_total_r + 5'd1;
              end else begin
                drop = 1'b1;
              end
            end
          end else begin
            desc_position_nxt = desc_position_r + 8'd1;
          end
        end
      end
    end

    // saturating drop count
    if (drop && drop_count_r != 16'hFFFF) begin
      drop_count_nxt = drop_count_r + 16'd1;
    end

    emit_st = in_data.final_byte;
    bad = error_seen_nxt || byte_count_nxt < 16'd9 || total_length_nxt != byte_count_nxt
          || desc_position_nxt != 8'd0;
    rec_st.record_kind     = KIND_STATUS;
    rec_st.status          = bad ? STATUS_INVALID : STATUS_VALID;
    rec_st.drop_total      = drop_count_nxt;
    rec_st.interfaces_kept = interface_total_nxt;

    if (in_data.final_byte) begin
      byte_count_nxt      = '0;
      total_length_nxt    = '0;
      desc_length_nxt     = '0;
      desc_kind_nxt       = '0;
      desc_position_nxt   = '0;
      interface_total_nxt = '0;
      endpoint_total_nxt  = '0;
      current_valid_nxt   = 1'b0;
      drop_count_nxt      = '0;
      error_seen_nxt      = 1'b0;
    end
  end

  // order of records for one beat: header, descriptor, status
  always_comb begin
    push = '0;
    if (accept) begin
      if (emit_hdr) begin
        push.first = rec_hdr;
        if (emit_fd) begin
          push.second = rec_fd;
          push.count  = 2'd2;
        end else if (emit_st) begin
          push.second = rec_st;
          push.count  = 2'd2;
        end else begin
          push.count = 2'd1;
        end
      end else if (emit_fd) begin
        push.first = rec_fd;
        if (emit_st) begin
          push.second = rec_st;
          push.count  = 2'd2;
        end else begin
          push.count = 2'd1;
        end
      end else if (emit_st) begin
        push.first = rec_st;
        push.count = 2'd1;
      end
      if (push.count == 2'd1) begin
        push.first.end_of_run = 1'b1;
      end else if (push.count == 2'd2) begin
        push.second.end_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r      <= '0;
      total_length_r    <= '0;
      desc_length_r     <= '0;
      desc_kind_r       <= '0;
      desc_position_r   <= '0;
      interface_total_r <= '0;
      endpoint_total_r  <= '0;
      current_valid_r   <= 1'b0;
      drop_count_r      <= '0;
      error_seen_r      <= 1'b0;
    end else if (accept) begin
      byte_count_r      <= byte_count_nxt;
      total_length_r    <= total_length_nxt;
      desc_length_r     <= desc_length_nxt;
      desc_kind_r       <= desc_kind_nxt;
      desc_position_r   <= desc_position_nxt;
      interface_total_r <= interface_total_nxt;
      endpoint_total_r  <= endpoint_total_nxt;
      current_valid_r   <= current_valid_nxt;
      drop_count_r      <= drop_count_nxt;
      error_seen_r      <= error_seen_nxt;
    end
  end

  // descriptor bytes, never read before written
  always_ff @(posedge clk) begin
    if (accept) begin
      desc_buffer_r <= desc_buffer_nxt;
    end
  end

  ucdw_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
